### hw/rtl/assert_macros.svh
// Assertion macros for the RTL that carries checks; only the core top level includes them.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### hw/rtl/tpfs_pkg.sv
// Package for the turning-point fragment segmenter: widths, codes and types.
// Used by every module of the block; depends on nothing.
package tpfs_pkg;

  localparam int IDX_W       = 20;
  localparam int LEN_W       = 21;
  localparam int RANGE_W     = 22;
  localparam int SAMPLE_W    = 16;
  localparam logic [LEN_W-1:0] MAX_SAMPLES = LEN_W'(1 << IDX_W);
  localparam logic [LEN_W-1:0] MIN_RECORD  = LEN_W'(10);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_FLAT = 2'd1;
  localparam logic [1:0] DIR_RISE = 2'd2;
  localparam logic [1:0] DIR_FALL = 2'd3;

  localparam int RES_N         = 5;
  localparam int RES_FIRST_EXT = 0;
  localparam int RES_FIRST_BR  = 1;
  localparam int RES_PAIR_EXT  = 2;
  localparam int RES_PAIR_BR   = 3;
  localparam int RES_FINAL_EXT = 4;

  localparam logic KIND_EXT    = 1'b0;
  localparam logic KIND_BRANCH = 1'b1;

  typedef struct packed {
    logic [RES_N-1:0] mask;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic [IDX_W-1:0] d;
    logic [IDX_W-1:0] fb;
    logic [IDX_W-1:0] idx;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

### hw/rtl/tpfs_if.sv
// Valid/ready channel interfaces for sample input and range output.
// Depends on tpfs_pkg for field widths.
interface tpfs_in_if;
  import tpfs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] target_sample;
  modport source (output valid, output target_sample, input ready);
  modport sink (input valid, input target_sample, output ready);
endinterface

interface tpfs_out_if;
  import tpfs_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      range_kind;
  logic signed [RANGE_W-1:0] range_begin;
  logic signed [RANGE_W-1:0] range_end;
  logic                      last_of_run;
  modport source (output valid, output range_kind, output range_begin,
                  output range_end, output last_of_run, input ready);
  modport sink (input valid, input range_kind, input range_begin,
                input range_end, input last_of_run, output ready);
endinterface

### hw/rtl/tpfs_front.sv
// Front part: accepts samples, tracks direction and marks, and queues the ranges a sample causes.
// Depends on tpfs_pkg.
module tpfs_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tpfs_pkg::LEN_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [tpfs_pkg::SAMPLE_W-1:0] target_sample,
  input  tpfs_pkg::fifo_stat_t            stat,
  output logic                            push,
  output tpfs_pkg::job_t                  job
);
  import tpfs_pkg::*;

  logic [LEN_W-1:0]           record_length;
  logic signed [SAMPLE_W-1:0] previous_sample;
  logic [1:0]                 direction;
  logic [IDX_W-1:0]           sample_index;
  logic [1:0]                 mark_count;
  logic [IDX_W-1:0]           older_mark;
  logic [IDX_W-1:0]           newer_mark;

  logic [LEN_W-1:0] len;
  logic             on, is_final, rise, fall, mark, accept, pair_mark, full_after;
  logic [1:0]       direction_next;
  logic [IDX_W-1:0] d1, d2;

  assign in_ready = !stat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    len       = (record_length > MAX_SAMPLES) ? MAX_SAMPLES : record_length;
    on        = len >= MIN_RECORD;
    is_final  = (len == '0) || (({1'b0, sample_index} + LEN_W'(1)) >= len);
    rise      = target_sample > previous_sample;
    fall      = target_sample < previous_sample;
    direction_next = direction;
    mark      = 1'b0;
    if (sample_index != '0) begin
      if (rise) begin
        mark = direction != DIR_RISE;
        direction_next = DIR_RISE;
      end else if (fall) begin
        mark = direction != DIR_FALL;
        direction_next = DIR_FALL;
      end else begin
        direction_next = DIR_FLAT;
      end
    end
    pair_mark  = mark && (mark_count >= 2'd2);
    full_after = (mark_count == 2'd3) || (mark && (mark_count == 2'd2));
    d1 = (newer_mark - older_mark) >> 2;
    d2 = (sample_index - newer_mark) >> 2;
    job.a   = older_mark + d1;
    job.b   = newer_mark - d1;
    job.c   = newer_mark + d2;
    job.d   = sample_index - d2;
    job.fb  = pair_mark ? job.d : job.b;
    job.idx = sample_index;
    job.mask = '0;
    job.mask[RES_FIRST_EXT] = on && mark && (mark_count == 2'd2);
    job.mask[RES_FIRST_BR]  = on && mark && (mark_count == 2'd2);
    job.mask[RES_PAIR_EXT]  = on && pair_mark;
    job.mask[RES_PAIR_BR]   = on && pair_mark;
    job.mask[RES_FINAL_EXT] = on && is_final && full_after;
  end

  assign push = accept && (job.mask != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      record_length   <= '0;
      previous_sample <= '0;
      direction       <= DIR_NONE;
      sample_index    <= '0;
      mark_count      <= '0;
      older_mark      <= '0;
      newer_mark      <= '0;
    end else begin
      if (cfg_we) begin
        record_length <= cfg_wdata;
      end
      if (accept) begin
        if (is_final) begin
          previous_sample <= '0;
          direction       <= DIR_NONE;
          sample_index    <= '0;
          mark_count      <= '0;
          older_mark      <= '0;
          newer_mark      <= '0;
        end else begin
          previous_sample <= target_sample;
          direction       <= direction_next;
          sample_index    <= sample_index + IDX_W'(1);
          if (mark) begin
            newer_mark <= sample_index;
            if (mark_count != 2'd0) begin
              older_mark <= newer_mark;
            end
            if (mark_count != 2'd3) begin
              mark_count <= mark_count + 2'd1;
            end
          end
        end
      end
    end
  end

endmodule

### hw/rtl/tpfs_fifo.sv
// Short queue of range requests between the front and back parts.
// Depends on tpfs_pkg for the entry type and depth.
module tpfs_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tpfs_pkg::job_t       wr_data,
  input  logic                 pop,
  output tpfs_pkg::job_t       rd_data,
  output tpfs_pkg::fifo_stat_t stat
);
  import tpfs_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign rd_data    = mem[rd_ptr];
  assign stat.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule

### hw/rtl/tpfs_back.sv
// Back part: takes queued range requests and sends their ranges one per cycle while the consumer is ready.
// Depends on tpfs_pkg; the output register decouples it from the consumer.
module tpfs_back (
  input  logic                                clk,
  input  logic                                rst,
  input  tpfs_pkg::fifo_stat_t                stat,
  input  tpfs_pkg::job_t                      head,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                range_kind,
  output logic signed [tpfs_pkg::RANGE_W-1:0] range_begin,
  output logic signed [tpfs_pkg::RANGE_W-1:0] range_end,
  output logic                                last_of_run
);
  import tpfs_pkg::*;

  logic             cur_valid;
  job_t             cur;
  logic [RES_N-1:0] mask_next;
  logic             advance, emit, done;
  logic             kind_sel;
  logic [RANGE_W-1:0] begin_sel, end_sel, a, b, c, d, fb, idx;

  assign advance = !out_valid || out_ready;
  assign emit    = advance && cur_valid;

  always_comb begin
    a   = RANGE_W'(cur.a);
    b   = RANGE_W'(cur.b);
    c   = RANGE_W'(cur.c);
    d   = RANGE_W'(cur.d);
    fb  = RANGE_W'(cur.fb);
    idx = RANGE_W'(cur.idx);
    mask_next = cur.mask;
    kind_sel  = KIND_EXT;
    begin_sel = fb;
    end_sel   = idx;
    if (cur.mask[RES_FIRST_EXT]) begin
      mask_next[RES_FIRST_EXT] = 1'b0;
      begin_sel = '0;
      end_sel   = a;
    end else if (cur.mask[RES_FIRST_BR]) begin
      mask_next[RES_FIRST_BR] = 1'b0;
      kind_sel  = KIND_BRANCH;
      begin_sel = a + RANGE_W'(1);
      end_sel   = b - RANGE_W'(1);
    end else if (cur.mask[RES_PAIR_EXT]) begin
      mask_next[RES_PAIR_EXT] = 1'b0;
      begin_sel = b;
      end_sel   = c;
    end else if (cur.mask[RES_PAIR_BR]) begin
      mask_next[RES_PAIR_BR] = 1'b0;
      kind_sel  = KIND_BRANCH;
      begin_sel = c + RANGE_W'(1);
      end_sel   = d - RANGE_W'(1);
    end else begin
      mask_next[RES_FINAL_EXT] = 1'b0;
    end
    done = mask_next == '0;
  end

  assign pop = !stat.empty && (!cur_valid || (emit && done));

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end else if (emit) begin
      cur.mask <= mask_next;
    end
    if (emit) begin
      range_kind  <= kind_sel;
      range_begin <= begin_sel;
      range_end   <= end_sel;
      last_of_run <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (emit && done) begin
        cur_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= cur_valid;
      end
    end
  end

endmodule

### hw/rtl/turning_point_fragment_segmenter_core.sv
// Top level of the turning-point fragment segmenter: front, request queue and back part.
// Depends on tpfs_pkg, tpfs_if.sv, assert_macros.svh, tpfs_front, tpfs_fifo and tpfs_back.
//
//   Channel      Dir   Handshake     Carries
//   sample_in    in    valid/ready   target_sample
//   range_out    out   valid/ready   range_kind, range_begin, range_end, last_of_run
//   cfg          in    cfg_we        record_length on cfg_wdata
//
// One sample is accepted per cycle while the four-entry request queue has room.
// A sample with k ranges holds the back part for all k, one per cycle unless stalled.
// Synchronous reset clears all record state and sets record_length to zero.
// Output stalls are absorbed by the output register and then by the queue.
`include "assert_macros.svh"

module turning_point_fragment_segmenter_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tpfs_pkg::LEN_W-1:0] cfg_wdata,
  tpfs_in_if.sink                    sample_in,
  tpfs_out_if.source                 range_out
);
  import tpfs_pkg::*;

  fifo_stat_t stat;
  job_t       wr_job;
  job_t       head;
  logic       push;
  logic       pop;

  tpfs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (sample_in.valid),
    .in_ready      (sample_in.ready),
    .target_sample (sample_in.target_sample),
    .stat          (stat),
    .push          (push),
    .job           (wr_job)
  );

  tpfs_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_job),
    .pop     (pop),
    .rd_data (head),
    .stat    (stat)
  );

  tpfs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .stat        (stat),
    .head        (head),
    .pop         (pop),
    .out_valid   (range_out.valid),
    .out_ready   (range_out.ready),
    .range_kind  (range_out.range_kind),
    .range_begin (range_out.range_begin),
    .range_end   (range_out.range_end),
    .last_of_run (range_out.last_of_run)
  );

  `ASSERT_IMPL(a_no_overflow, push, !stat.full)
  `ASSERT_IMPL(a_no_underflow, pop, !stat.empty)
  `ASSERT_NEXT(a_push_fills, push && !pop, !stat.empty)

endmodule
